### hw/rtl/ansi_pkg.sv
// ============================================================================
// ANSI encoder package
// Shared types and constants for the truecolor terminal encoder.
// ============================================================================
package ansi_pkg;

    localparam int GLYPH_MAX_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH_DEF     = 2;

    // Byte codes of the stream
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_TWO  = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR = 8'h34;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] HB_0    = 8'hE2;
    localparam logic [7:0] HB_1    = 8'h96;
    localparam logic [7:0] HB_2    = 8'h80;

    // Register indexes
    localparam logic [1:0] REG_HALF  = 2'd0;
    localparam logic [1:0] REG_LUM   = 2'd1;
    localparam logic [1:0] REG_GLYPH = 2'd2;
    localparam logic [1:0] REG_GLEN  = 2'd3;

    // Glyph selection
    typedef enum logic [1:0] {
        GK_HALF   = 2'd0,
        GK_RAMP   = 2'd1,
        GK_CUSTOM = 2'd2
    } glyph_kind_t;

    // Decimal digits of one colour component
    typedef struct packed {
        logic [1:0] ndig;
        logic [7:0] d2;
        logic [7:0] d1;
        logic [7:0] d0;
    } dec_t;

    // One classified cell
    typedef struct packed {
        logic        home;
        logic        fore_sgr;
        dec_t [2:0]  fore_dec;
        logic        back_sgr;
        dec_t [2:0]  back_dec;
        glyph_kind_t kind;
        logic [7:0]  ramp_char;
        logic [63:0] glyph;
        logic [3:0]  glen;
        logic        row_end;
        logic        crlf;
    } cmd_t;

    function automatic logic [7:0] ramp_lut(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0: c = 8'h20;
            4'd1: c = 8'h2E;
            4'd2: c = 8'h3A;
            4'd3: c = 8'h2D;
            4'd4: c = 8'h3D;
            4'd5: c = 8'h2B;
            4'd6: c = 8'h2A;
            4'd7: c = 8'h23;
            4'd8: c = 8'h25;
            default: c = 8'h40;
        endcase
        return c;
    endfunction

    // Decimal digits of a byte: a subtract ladder for hundreds, a multiply-shift for tens
    function automatic dec_t to_dec(input logic [7:0] v);
        dec_t d;
        logic [7:0] r;
        logic [3:0] h;
        logic [3:0] t;
        r = v;
        h = 4'd0;
        if (r >= 8'd200) begin h = 4'd2; r = r - 8'd200; end
        else if (r >= 8'd100) begin h = 4'd1; r = r - 8'd100; end
        t = 4'(({8'b0, r} * 16'd205) >> 11);
        r = r - 8'(t) * 8'd10;
        d.d2 = CH_ZERO + 8'(h);
        d.d1 = CH_ZERO + 8'(t);
        d.d0 = CH_ZERO + r;
        d.ndig = (v >= 8'd100) ? 2'd3 : ((v >= 8'd10) ? 2'd2 : 2'd1);
        return d;
    endfunction

endpackage

### hw/rtl/ansi_front.sv
// ============================================================================
// ANSI encoder front end
// Accepts cells, tracks row colour state and emits one command per cell.
// ============================================================================
module ansi_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [51:0]          in_data,
    input  logic                 half_block_mode,
    input  logic                 luminance_mode,
    input  logic [63:0]          glyph_bytes,
    input  logic [3:0]           glen,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output ansi_pkg::cmd_t       cmd
);

    logic [23:0] fore_reg, back_reg;
    logic        fv_reg, bv_reg;
    logic [23:0] lum_prod_reg;
    logic        s1_valid_reg;
    logic [51:0] s1_data_reg;
    logic        fore_next_sgr, back_next_sgr;
    logic [23:0] fore_c, back_c;
    logic [7:0]  lum;
    logic [3:0]  ridx;
    logic        s1_adv;
    logic        in_acc;
    ansi_pkg::cmd_t cmd_reg, cmd_next;
    logic        cmd_valid_reg;

    // Stage 1 advances when the output command register is free or being read
    assign s1_adv   = s1_valid_reg && (!cmd_valid_reg || cmd_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_acc   = in_valid && in_ready;

    // Stage 1: capture cell and luminance product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_data_reg  <= in_data;
            lum_prod_reg <= 24'(16'd77 * in_data[8:1]) + 24'(16'd150 * in_data[16:9])
                          + 24'(16'd29 * in_data[24:17]);
        end
    end

    // Classify against row colour state
    always_comb
    begin
        logic home;
        logic fv, bv;
        logic [23:0] fl, bl;
        home   = s1_data_reg[0];
        fore_c = {s1_data_reg[8:1], s1_data_reg[16:9], s1_data_reg[24:17]};
        back_c = s1_data_reg[49] ?
                 {s1_data_reg[32:25], s1_data_reg[40:33], s1_data_reg[48:41]} : 24'd0;
        fv = fv_reg && !home;
        bv = bv_reg && !home;
        fl = home ? 24'd0 : fore_reg;
        bl = home ? 24'd0 : back_reg;
        fore_next_sgr = !fv || (fl != fore_c);
        back_next_sgr = half_block_mode && (!bv || (bl != back_c));
        lum  = lum_prod_reg[15:8];
        // Ramp step: lum * 9 / 255 as threshold compares
        priority if (lum >= 8'd255) ridx = 4'd9;
        else if (lum >= 8'd227) ridx = 4'd8;
        else if (lum >= 8'd199) ridx = 4'd7;
        else if (lum >= 8'd170) ridx = 4'd6;
        else if (lum >= 8'd142) ridx = 4'd5;
        else if (lum >= 8'd114) ridx = 4'd4;
        else if (lum >= 8'd85)  ridx = 4'd3;
        else if (lum >= 8'd57)  ridx = 4'd2;
        else if (lum >= 8'd29)  ridx = 4'd1;
        else                    ridx = 4'd0;
        cmd_next.home      = home;
        cmd_next.fore_sgr  = fore_next_sgr;
        cmd_next.fore_dec  = {ansi_pkg::to_dec(fore_c[7:0]), ansi_pkg::to_dec(fore_c[15:8]),
                              ansi_pkg::to_dec(fore_c[23:16])};
        cmd_next.back_sgr  = back_next_sgr;
        cmd_next.back_dec  = {ansi_pkg::to_dec(back_c[7:0]), ansi_pkg::to_dec(back_c[15:8]),
                              ansi_pkg::to_dec(back_c[23:16])};
        cmd_next.kind      = half_block_mode ? ansi_pkg::GK_HALF :
                             (luminance_mode ? ansi_pkg::GK_RAMP : ansi_pkg::GK_CUSTOM);
        cmd_next.ramp_char = ansi_pkg::ramp_lut(ridx);
        cmd_next.glyph     = glyph_bytes;
        cmd_next.glen      = glen;
        cmd_next.row_end   = s1_data_reg[50];
        cmd_next.crlf      = !s1_data_reg[51];
    end

    // Stage 2: update colour state, hold command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_reg      <= 24'd0;
            back_reg      <= 24'd0;
            fv_reg        <= 1'b0;
            bv_reg        <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= s1_adv || (cmd_valid_reg && !cmd_ready);
            if (s1_adv)
            begin
                if (s1_data_reg[50])
                begin
                    fore_reg <= 24'd0;
                    back_reg <= 24'd0;
                    fv_reg   <= 1'b0;
                    bv_reg   <= 1'b0;
                end
                else
                begin
                    fore_reg <= fore_c;
                    fv_reg   <= 1'b1;
                    if (half_block_mode)
                    begin
                        back_reg <= back_c;
                        bv_reg   <= 1'b1;
                    end
                    else if (s1_data_reg[0])
                    begin
                        back_reg <= 24'd0;
                        bv_reg   <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            cmd_reg <= cmd_next;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    // Checks
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg && !cmd_ready |=> cmd_valid_reg && $stable(cmd_reg))
        else $error("command dropped while stalled");
    a_state: assert property (@(posedge clk) disable iff (!rst_n)
        !fv_reg |-> fore_reg == 24'd0)
        else $error("foreground colour kept without valid");
    a_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg)
        else $error("stage 1 item lost");

endmodule

### hw/rtl/ansi_queue.sv
// ============================================================================
// ANSI encoder command queue
// Short FIFO between the classifier and the byte sequencer.
// ============================================================================
module ansi_queue
#(
    parameter int DEPTH = ansi_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  ansi_pkg::cmd_t wr_cmd,
    output logic           rd_valid,
    input  logic           rd_ready,
    output ansi_pkg::cmd_t rd_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ansi_pkg::cmd_t mem [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;
    logic           wr, rd;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_cmd = mem[rp_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_cmd;
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue overflow");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 && !wr |=> cnt_reg == '0)
        else $error("queue count moved without write");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (AW+1)'(DEPTH)) && !rd |=> cnt_reg == (AW+1)'(DEPTH))
        else $error("queue count moved without read");

endmodule

### hw/rtl/ansi_back.sv
// ============================================================================
// ANSI encoder back end
// Walks one command byte by byte and drives the output register.
// ============================================================================
module ansi_back
#(
    parameter int GLYPH_MAX_BYTES = ansi_pkg::GLYPH_MAX_BYTES_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  ansi_pkg::cmd_t cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           out_last
);

    // Sequencer phases
    typedef enum logic [10:0] {
        PH_HOME  = 11'b00000000001,
        PH_FPRE  = 11'b00000000010,
        PH_FDIG  = 11'b00000000100,
        PH_BPRE  = 11'b00000001000,
        PH_BDIG  = 11'b00000010000,
        PH_GLYPH = 11'b00000100000,
        PH_RST   = 11'b00001000000,
        PH_CRLF  = 11'b00010000000,
        PH_IDLE  = 11'b00100000000,
        PH_FEND  = 11'b01000000000,
        PH_BEND  = 11'b10000000000
    } phase_t;

    localparam int GW = $clog2(GLYPH_MAX_BYTES + 1);

    phase_t         ph_reg, ph_next;
    logic [3:0]     idx_reg, idx_next;
    logic [1:0]     comp_reg, comp_next;
    logic           act_reg;
    ansi_pkg::cmd_t cur_reg;
    logic [7:0]     byte_c;
    logic           last_c;
    logic           emit;
    logic           ov_reg;
    logic [7:0]     ob_reg;
    logic           ol_reg;
    logic [GW-1:0]  glen_c;
    logic [3:0]     glen_last;
    ansi_pkg::dec_t dsel;
    logic [1:0]     nd;

    assign emit = act_reg && (!ov_reg || out_ready);
    assign cmd_ready = !act_reg || (emit && last_c);

    // Clamp glyph length
    always_comb
    begin
        if (cur_reg.glen == 4'd0)
            glen_c = GW'(1);
        else if (cur_reg.glen > 4'(GLYPH_MAX_BYTES))
            glen_c = GW'(GLYPH_MAX_BYTES);
        else
            glen_c = GW'(cur_reg.glen);
        glen_last = 4'(glen_c) - 4'd1;
    end

    // Pick the current byte and the following position
    always_comb
    begin
        phase_t after_glyph;
        phase_t after_fore;
        after_glyph = cur_reg.row_end ? PH_RST : PH_IDLE;
        after_fore  = cur_reg.back_sgr ? PH_BPRE : PH_GLYPH;
        dsel = (ph_reg == PH_BDIG) ? cur_reg.back_dec[comp_reg] : cur_reg.fore_dec[comp_reg];
        nd = dsel.ndig;
        byte_c = 8'h00;
        ph_next = ph_reg;
        idx_next = idx_reg + 4'd1;
        comp_next = comp_reg;
        unique case (ph_reg)
            PH_HOME:
            begin
                byte_c = (idx_reg == 4'd0) ? ansi_pkg::CH_ESC :
                         (idx_reg == 4'd1) ? ansi_pkg::CH_LBR : ansi_pkg::CH_H;
                if (idx_reg == 4'd2)
                begin
                    idx_next = 4'd0;
                    ph_next = cur_reg.fore_sgr ? PH_FPRE : after_fore;
                end
            end
            PH_FPRE, PH_BPRE:
            begin
                unique case (idx_reg)
                    4'd0: byte_c = ansi_pkg::CH_ESC;
                    4'd1: byte_c = ansi_pkg::CH_LBR;
                    4'd2: byte_c = (ph_reg == PH_FPRE) ? ansi_pkg::CH_THREE
                                                       : ansi_pkg::CH_FOUR;
                    4'd3: byte_c = ansi_pkg::CH_EIGHT;
                    4'd5: byte_c = ansi_pkg::CH_TWO;
                    default: byte_c = ansi_pkg::CH_SEMI;
                endcase
                if (idx_reg == 4'd6)
                begin
                    idx_next = 4'd0;
                    comp_next = 2'd0;
                    ph_next = (ph_reg == PH_FPRE) ? PH_FDIG : PH_BDIG;
                end
            end
            PH_FDIG, PH_BDIG:
            begin
                // Digits from most significant, then a separator
                if (idx_reg == 4'(nd))
                begin
                    byte_c = (comp_reg == 2'd2) ? ansi_pkg::CH_M : ansi_pkg::CH_SEMI;
                    idx_next = 4'd0;
                    if (comp_reg == 2'd2)
                        ph_next = (ph_reg == PH_FDIG) ? after_fore : PH_GLYPH;
                    else
                        comp_next = comp_reg + 2'd1;
                end
                else
                begin
                    priority case (4'(nd) - idx_reg)
                        4'd3: byte_c = dsel.d2;
                        4'd2: byte_c = dsel.d1;
                        default: byte_c = dsel.d0;
                    endcase
                end
            end
            PH_GLYPH:
            begin
                unique case (cur_reg.kind)
                    ansi_pkg::GK_HALF:
                    begin
                        byte_c = (idx_reg == 4'd0) ? ansi_pkg::HB_0 :
                                 (idx_reg == 4'd1) ? ansi_pkg::HB_1 : ansi_pkg::HB_2;
                        if (idx_reg == 4'd2) begin idx_next = 4'd0; ph_next = after_glyph; end
                    end
                    ansi_pkg::GK_RAMP:
                    begin
                        byte_c = cur_reg.ramp_char;
                        idx_next = 4'd0;
                        ph_next = after_glyph;
                    end
                    default:
                    begin
                        byte_c = cur_reg.glyph[{idx_reg[2:0], 3'b000} +: 8];
                        if (idx_reg == glen_last)
                        begin
                            idx_next = 4'd0;
                            ph_next = after_glyph;
                        end
                    end
                endcase
            end
            PH_RST:
            begin
                byte_c = (idx_reg == 4'd0) ? ansi_pkg::CH_ESC :
                         (idx_reg == 4'd1) ? ansi_pkg::CH_LBR :
                         (idx_reg == 4'd2) ? ansi_pkg::CH_ZERO : ansi_pkg::CH_M;
                if (idx_reg == 4'd3) begin idx_next = 4'd0; ph_next = PH_CRLF; end
            end
            PH_CRLF:
            begin
                byte_c = (idx_reg == 4'd0) ? ansi_pkg::CH_CR : ansi_pkg::CH_LF;
            end
            default:
            begin
                byte_c = 8'h00;
            end
        endcase
        last_c = (ph_next == PH_IDLE)
              || (ph_reg == PH_RST && idx_reg == 4'd3 && !cur_reg.crlf)
              || (ph_reg == PH_CRLF && idx_reg == 4'd1);
    end

    // Start position of a fresh command
    function automatic phase_t start_ph(input ansi_pkg::cmd_t c);
        phase_t p;
        if (c.home) p = PH_HOME;
        else if (c.fore_sgr) p = PH_FPRE;
        else if (c.back_sgr) p = PH_BPRE;
        else p = PH_GLYPH;
        return p;
    endfunction

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            idx_reg  <= 4'd0;
            comp_reg <= 2'd0;
            act_reg  <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            ov_reg <= emit || (ov_reg && !out_ready);
            if (cmd_ready)
            begin
                act_reg  <= cmd_valid;
                ph_reg   <= start_ph(cmd);
                idx_reg  <= 4'd0;
                comp_reg <= 2'd0;
            end
            else if (emit)
            begin
                ph_reg   <= ph_next;
                idx_reg  <= idx_next;
                comp_reg <= comp_next;
            end
        end
    end

    // Hold the command being sequenced
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            cur_reg <= cmd;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ob_reg <= byte_c;
            ol_reg <= last_c;
        end
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_last  = ol_reg;

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ready |=> ov_reg && $stable(ob_reg))
        else $error("output byte changed under stall");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && act_reg |-> last_c)
        else $error("command taken mid-sequence");
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg |-> idx_reg <= 4'd7)
        else $error("byte index out of range");

endmodule

### hw/rtl/pixel_to_ansi_truecolor_stream.sv
// ============================================================================
// ANSI truecolor stream encoder
// Turns terminal cells into ANSI escape bytes, one per cycle unless stalled.
// ============================================================================
// channel   dir  handshake        payload
// s_axis    in   tvalid/tready    tdata: cell fields, 52 bits in 56
// m_axis    out  tvalid/tready    tdata: out_byte, tlast: out_last
// apb       in   psel/penable     4 registers at 8*i, 64-bit data
//
// One output byte per cycle while m_axis_tready holds; the byte sequencer in
// the back end sets the bytes of a cell. A new cell enters every cycle while
// the command queue has room. Reset clears colour state and all valid flags and
// loads register defaults; output stalls back up the queue to s_axis_tready.
module pixel_to_ansi_truecolor_stream
#(
    parameter int GLYPH_MAX_BYTES = ansi_pkg::GLYPH_MAX_BYTES_DEF,
    parameter int QUEUE_DEPTH     = ansi_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: frame_start, top_red, top_green, top_blue, bottom_red,
    // bottom_green, bottom_blue, bottom_present, row_end, final_row, zero pad
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: out_byte
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic        half_reg, lum_reg;
    logic [63:0] glyph_reg;
    logic [3:0]  glen_reg;
    logic [1:0]  ridx;
    logic        f_valid, f_ready, q_valid, q_ready;
    ansi_pkg::cmd_t f_cmd, q_cmd;

    assign pready = 1'b1;
    assign ridx = paddr[4:3];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg  <= 1'b0;
            lum_reg   <= 1'b0;
            glyph_reg <= 64'd35;
            glen_reg  <= 4'd1;
        end
        else if (psel && penable && pwrite && paddr[2:0] == 3'd0)
        begin
            unique case (ridx)
                ansi_pkg::REG_HALF:  half_reg  <= pwdata[0];
                ansi_pkg::REG_LUM:   lum_reg   <= pwdata[0];
                ansi_pkg::REG_GLYPH: glyph_reg <= pwdata;
                default:             glen_reg  <= pwdata[3:0];
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (ridx)
            ansi_pkg::REG_HALF:  prdata = {63'd0, half_reg};
            ansi_pkg::REG_LUM:   prdata = {63'd0, lum_reg};
            ansi_pkg::REG_GLYPH: prdata = glyph_reg;
            default:             prdata = {60'd0, glen_reg};
        endcase
    end

    ansi_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_data         (s_axis_tdata[51:0]),
        .half_block_mode (half_reg),
        .luminance_mode  (lum_reg),
        .glyph_bytes     (glyph_reg),
        .glen            (glen_reg),
        .cmd_valid       (f_valid),
        .cmd_ready       (f_ready),
        .cmd             (f_cmd)
    );

    ansi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_cmd   (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_cmd   (q_cmd)
    );

    ansi_back #(.GLYPH_MAX_BYTES(GLYPH_MAX_BYTES)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
